>>> rtl/core/srla_pkg.sv
// ----------------------------------------------------------------------------
// srla_pkg
// Shared types, operation codes and encoding checks for the SIMD lane ALU.
// ----------------------------------------------------------------------------
package srla_pkg;

    localparam int NUM_VREGS = 32;
    localparam int VREG_AW   = $clog2(NUM_VREGS);

    localparam logic [3:0] F_WRITE = 4'd0;
    localparam logic [3:0] F_DUP   = 4'd1;
    localparam logic [3:0] F_MLA   = 4'd2;
    localparam logic [3:0] F_MLS   = 4'd3;
    localparam logic [3:0] F_ABAU  = 4'd4;
    localparam logic [3:0] F_ABAS  = 4'd5;
    localparam logic [3:0] F_PADD  = 4'd6;
    localparam logic [3:0] F_PMAXU = 4'd7;
    localparam logic [3:0] F_PMINU = 4'd8;
    localparam logic [3:0] F_PMAXS = 4'd9;
    localparam logic [3:0] F_PMINS = 4'd10;

    localparam logic [1:0] LS_NONE = 2'd0;
    localparam logic [1:0] LS_8    = 2'd1;
    localparam logic [1:0] LS_16   = 2'd2;
    localparam logic [1:0] LS_32   = 2'd3;

    localparam logic [1:0] CNT_D = 2'd1;
    localparam logic [1:0] CNT_Q = 2'd2;

    localparam logic [3:0] GPR_BAD = 4'd15;

    typedef struct packed {
        logic [3:0]  func;
        logic [4:0]  dest_reg;
        logic [4:0]  src_n_reg;
        logic [4:0]  src_m_reg;
        logic [1:0]  lane_size;
        logic [1:0]  reg_count;
        logic [3:0]  gpr_index;
        logic [31:0] gpr_value;
        logic [63:0] write_value;
    } t_in;

    typedef struct packed {
        logic [4:0]  out_reg;
        logic [63:0] out_value;
        logic        undefined;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [3:0] func;
        logic [1:0] lane_size;
    } t_lane_ctl;

    function automatic logic srla_fits(logic [4:0] idx, logic [1:0] cnt);
        return ({2'b00, idx} + {5'b00000, cnt}) <= 7'(NUM_VREGS);
    endfunction

    function automatic logic srla_is_undef(t_in x);
        logic bad;
        bad = 1'b0;
        if (x.func > F_PMINS) begin
            bad = 1'b1;
        end else if (x.func == F_WRITE) begin
            bad = !srla_fits(x.dest_reg, CNT_D);
        end else if (x.lane_size == LS_NONE) begin
            bad = 1'b1;
        end else if (x.func == F_DUP) begin
            bad = (x.reg_count != CNT_D && x.reg_count != CNT_Q) ||
                  (x.gpr_index == GPR_BAD) ||
                  (x.reg_count == CNT_Q && x.dest_reg[0]) ||
                  !srla_fits(x.dest_reg, x.reg_count);
        end else if (x.func <= F_ABAS) begin
            bad = (x.reg_count != CNT_D && x.reg_count != CNT_Q) ||
                  (x.reg_count == CNT_Q &&
                   (x.dest_reg[0] | x.src_n_reg[0] | x.src_m_reg[0])) ||
                  !srla_fits(x.dest_reg, x.reg_count) ||
                  !srla_fits(x.src_n_reg, x.reg_count) ||
                  !srla_fits(x.src_m_reg, x.reg_count);
        end else begin
            bad = (x.reg_count != CNT_D) ||
                  !srla_fits(x.dest_reg, CNT_D) ||
                  !srla_fits(x.src_n_reg, CNT_D) ||
                  !srla_fits(x.src_m_reg, CNT_D);
        end
        return bad;
    endfunction

endpackage

>>> rtl/core/srla_ram.sv
// ----------------------------------------------------------------------------
// srla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/core/srla_lane_unit.sv
// ----------------------------------------------------------------------------
// srla_lane_unit
// One-lane arithmetic unit: multiply-accumulate, absolute difference and
// pairwise add, max and min on a lane of 8, 16 or 32 bits.
// ----------------------------------------------------------------------------
module srla_lane_unit (
    input  srla_pkg::t_lane_ctl i_ctl,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    input  logic [31:0]         i_d,
    output logic [31:0]         o_s
);
    import srla_pkg::*;

    logic [31:0]        mask;
    logic [31:0]        am, bm, dm, prod, s;
    logic signed [32:0] sa, sb, sdiff;

    always_comb begin
        unique case (i_ctl.lane_size)
            LS_8:    mask = 32'h0000_00ff;
            LS_16:   mask = 32'h0000_ffff;
            default: mask = 32'hffff_ffff;
        endcase
        am = i_a & mask;
        bm = i_b & mask;
        dm = i_d & mask;
        unique case (i_ctl.lane_size)
            LS_8: begin
                sa = {{25{am[7]}}, am[7:0]};
                sb = {{25{bm[7]}}, bm[7:0]};
            end
            LS_16: begin
                sa = {{17{am[15]}}, am[15:0]};
                sb = {{17{bm[15]}}, bm[15:0]};
            end
            default: begin
                sa = {am[31], am};
                sb = {bm[31], bm};
            end
        endcase
        prod  = am * bm;
        sdiff = (sa >= sb) ? (sa - sb) : (sb - sa);
        unique case (i_ctl.func)
            F_MLA:   s = dm + prod;
            F_MLS:   s = dm - prod;
            F_ABAU:  s = dm + ((am >= bm) ? (am - bm) : (bm - am));
            F_ABAS:  s = dm + sdiff[31:0];
            F_PADD:  s = am + bm;
            F_PMAXU: s = (am >= bm) ? am : bm;
            F_PMINU: s = (am <= bm) ? am : bm;
            F_PMAXS: s = (sa >= sb) ? am : bm;
            F_PMINS: s = (sa <= sb) ? am : bm;
            default: s = 32'd0;
        endcase
        o_s = s & mask;
    end

endmodule

>>> rtl/core/simd_register_lane_alu_core.sv
// ----------------------------------------------------------------------------
// simd_register_lane_alu_core
// SIMD integer lane ALU over a file of 64-bit vector registers.
//
//   channel | direction | valid       | stall       | payload
//   in      | input     | i_in_valid  | o_in_stall  | i_in_data  (t_in)
//   out     | output    | o_out_valid | i_out_stall | o_out_data (t_out)
//
// write, dup and rejected transactions pass through decode, write and output.
// accumulate passes per register through decode, three register file reads
// through one port, one lane per cycle in the shared lane unit, write and
// output; pairwise does the same with two register file reads.
// reset clears the per-register valid bits at once: unwritten registers read
// as zero, no clearing pass.
// while a result is stalled the block holds it and accepts no transaction.
// ----------------------------------------------------------------------------
module simd_register_lane_alu_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  srla_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output srla_pkg::t_out   o_out_data
);
    import srla_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_LANE = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0]           r_state;
    t_in                  r_in;
    logic                 r_hi, r_undef, r_last, r_out_valid, r_rd_vld;
    logic [2:0]           r_lane;
    logic [63:0]          r_nv, r_mv, r_dv, r_res;
    t_out                 r_out;
    logic [NUM_VREGS-1:0] r_vld;

    logic [4:0]   d_cur, n_cur, m_cur, rd_idx;
    logic [63:0]  rd_q, ram_q, bcast, nv_sh, mv_sh, dv_sh;
    logic [127:0] pair_sh;
    logic [31:0]  lane_a, lane_b, lane_s;
    logic [63:0]  res_ins;
    logic [2:0]   lane_last;
    logic         is_acc, ram_we;
    t_lane_ctl    lane_ctl;

    assign d_cur  = r_in.dest_reg + {4'd0, r_hi};
    assign n_cur  = r_in.src_n_reg + {4'd0, r_hi};
    assign m_cur  = r_in.src_m_reg + {4'd0, r_hi};
    assign is_acc = (r_in.func <= F_ABAS);
    assign ram_we = (r_state == S_WR) && !r_undef;

    always_comb begin
        unique case (r_state)
            S_DEC:   rd_idx = n_cur;
            S_RD1:   rd_idx = m_cur;
            default: rd_idx = d_cur;
        endcase
    end

    srla_ram #(
        .WIDTH (64),
        .DEPTH (NUM_VREGS)
    ) u_vregs (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (d_cur[VREG_AW-1:0]),
        .i_wdata (r_res),
        .i_raddr (rd_idx[VREG_AW-1:0]),
        .o_rdata (ram_q)
    );

    // never-written registers read as zero
    assign rd_q = r_rd_vld ? ram_q : 64'd0;

    always_comb begin
        unique case (r_in.lane_size)
            LS_8: begin
                bcast     = {8{r_in.gpr_value[7:0]}};
                nv_sh     = r_nv >> 8;
                mv_sh     = r_mv >> 8;
                dv_sh     = r_dv >> 8;
                pair_sh   = {r_mv, r_nv} >> 16;
                lane_last = 3'd7;
                res_ins   = {lane_s[7:0], r_res[63:8]};
            end
            LS_16: begin
                bcast     = {4{r_in.gpr_value[15:0]}};
                nv_sh     = r_nv >> 16;
                mv_sh     = r_mv >> 16;
                dv_sh     = r_dv >> 16;
                pair_sh   = {r_mv, r_nv} >> 32;
                lane_last = 3'd3;
                res_ins   = {lane_s[15:0], r_res[63:16]};
            end
            default: begin
                bcast     = {2{r_in.gpr_value}};
                nv_sh     = r_nv >> 32;
                mv_sh     = r_mv >> 32;
                dv_sh     = r_dv >> 32;
                pair_sh   = {r_mv, r_nv} >> 64;
                lane_last = 3'd1;
                res_ins   = {lane_s, r_res[63:32]};
            end
        endcase
        lane_a = r_nv[31:0];
        lane_b = is_acc ? r_mv[31:0] : nv_sh[31:0];
    end

    assign lane_ctl = '{func: r_in.func, lane_size: r_in.lane_size};

    srla_lane_unit u_lane (
        .i_ctl (lane_ctl),
        .i_a   (lane_a),
        .i_b   (lane_b),
        .i_d   (r_dv[31:0]),
        .o_s   (lane_s)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[rd_idx[VREG_AW-1:0]];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_hi    <= 1'b0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_lane <= 3'd0;
                    if (srla_is_undef(r_in)) begin
                        r_undef <= 1'b1;
                        r_last  <= 1'b1;
                        r_state <= S_WR;
                    end else begin
                        r_undef <= 1'b0;
                        r_last  <= (r_in.func == F_WRITE) || (r_in.func >= F_PADD) ||
                                   (r_in.reg_count == CNT_D) || r_hi;
                        if (r_in.func == F_WRITE) begin
                            r_res   <= r_in.write_value;
                            r_state <= S_WR;
                        end else if (r_in.func == F_DUP) begin
                            r_res   <= bcast;
                            r_state <= S_WR;
                        end else begin
                            r_state <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    r_nv    <= rd_q;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_mv    <= rd_q;
                    r_state <= is_acc ? S_RD3 : S_LANE;
                end
                S_RD3: begin
                    r_dv    <= rd_q;
                    r_state <= S_LANE;
                end
                S_LANE: begin
                    r_res <= res_ins;
                    if (is_acc) begin
                        r_nv <= nv_sh;
                        r_mv <= mv_sh;
                        r_dv <= dv_sh;
                    end else begin
                        {r_mv, r_nv} <= pair_sh;
                    end
                    r_lane <= r_lane + 3'd1;
                    if (r_lane == lane_last) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_out_valid <= 1'b1;
                    if (r_undef) begin
                        r_out <= '{out_reg: 5'd0, out_value: 64'd0, undefined: 1'b1,
                                   last: 1'b1};
                    end else begin
                        r_out <= '{out_reg: d_cur, out_value: r_res, undefined: 1'b0,
                                   last: r_last};
                        r_vld[d_cur[VREG_AW-1:0]] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_hi    <= 1'b1;
                            r_state <= S_DEC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_undef_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.undefined |->
            o_out_data.last && o_out_data.out_value == 64'd0)
        else $error("rejected transaction result not clean");

    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    a_lane_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LANE |=> r_state == S_LANE || r_state == S_WR)
        else $error("lane loop left to a wrong state");

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT)
        else $error("result valid outside output state");
`endif

endmodule
